FILE: hw/rtl/blps_pkg.sv
package blps_pkg;

  // input and result beats
  typedef struct packed {
    logic        opcode;
    logic [15:0] millivolts;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        active;
    logic [3:0]  pulses_planned;
  } out_item_t;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_PERCENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEPS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS       = 3'd5;

  localparam logic [15:0] RST_PWM_PERIOD   = 16'd1000;
  localparam logic [6:0]  RST_PEAK_PERCENT = 7'd5;
  localparam logic [5:0]  RST_FADE_STEPS   = 6'd12;
  localparam logic [7:0]  RST_STEP_MS      = 8'd6;
  localparam logic [9:0]  RST_HOLD_MS      = 10'd50;
  localparam logic [9:0]  RST_GAP_MS       = 10'd80;

  // battery window and pulse plan: one pulse, plus one per 150 mV above the floor
  localparam logic [15:0] MV_MIN      = 16'd3000;
  localparam logic [15:0] MV_MAX      = 16'd4200;
  localparam logic [10:0] MV_PER_STEP = 11'd150;
  localparam int          GOAL_MAX    = 8;

  // step divider: 13-bit step * percent over a 7-bit step count
  localparam int DIV_W   = 13;
  localparam int DIVR_W  = 7;
  localparam int DCNT_W  = 4;

  // period * percent fits 29 bits; /100 done as (x/4)/25 by reciprocal,
  // ceil(2^32 / 25), exact for every 27-bit x/4
  localparam int          PROD_W       = 29;
  localparam logic [27:0] DIV100_RECIP = 28'd171798692;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic mul_load;
    logic width_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_width;
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/blps_div.sv
module blps_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [blps_pkg::DIV_W-1:0]       dividend,
  input  logic [blps_pkg::DIVR_W-1:0]      divisor,
  output logic                             busy,
  output logic [blps_pkg::DIV_W-1:0]       quotient
);

  logic                          busy_r;
  logic [blps_pkg::DCNT_W-1:0]   cnt_r;
  logic [blps_pkg::DIVR_W-1:0]   rem_r;
  logic [blps_pkg::DIVR_W-1:0]   dvs_r;
  logic [blps_pkg::DIV_W-1:0]    quo_r;

  logic [blps_pkg::DIVR_W:0]     trial;
  logic [blps_pkg::DIVR_W:0]     diff;
  logic                          qbit;

  // restoring step: one quotient bit per cycle, MSB first
  assign trial = {rem_r, quo_r[blps_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= blps_pkg::DCNT_W'(blps_pkg::DIV_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[blps_pkg::DIVR_W-1:0] : trial[blps_pkg::DIVR_W-1:0];
      quo_r <= {quo_r[blps_pkg::DIV_W-2:0], qbit};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/blps_datapath.sv
module blps_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  blps_pkg::cmd_t                     cmd,
  output blps_pkg::sts_t                     sts,
  input  blps_pkg::in_item_t                 in_data,
  input  logic                               cfg_we,
  input  logic [blps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               out_stall,
  output logic                               out_valid,
  output blps_pkg::out_item_t                out_data
);

  typedef enum logic [1:0] {
    PH_FADE_IN,
    PH_HOLD,
    PH_FADE_OUT,
    PH_GAP
  } phase_t;

  // config
  logic [15:0] pwm_period_r;
  logic [6:0]  peak_percent_r;
  logic [5:0]  fade_steps_r;
  logic [7:0]  step_ms_r;
  logic [9:0]  hold_ms_r;
  logic [9:0]  gap_ms_r;

  // sequence state
  blps_pkg::in_item_t item_r;
  phase_t      phase_r, phase_nxt;
  logic [5:0]  ramp_r, ramp_nxt;
  logic [3:0]  goal_r, goal_nxt;
  logic [3:0]  done_r, done_nxt;
  logic [9:0]  delay_r, delay_nxt;
  logic        running_r, running_nxt;
  logic [15:0] width_r, width_nxt;
  logic        need_width;

  logic [blps_pkg::PROD_W-1:0] prod_r;
  logic [blps_pkg::PROD_W-1:0] prod_calc;
  logic [54:0]                 scale_mul;
  logic [22:0]                 width_q;
  logic [12:0]                 pct_num;
  logic [blps_pkg::DIV_W-1:0]  div_dividend;
  logic [blps_pkg::DIVR_W-1:0] div_divisor;
  logic [blps_pkg::DIV_W-1:0]  div_q;
  logic                        div_busy;

  blps_pkg::out_item_t out_r;
  logic                out_valid_r;

  logic [5:0]  steps;
  logic [15:0] mv_clamped;
  logic [10:0] mv_over;
  logic [3:0]  goal_calc;

  function automatic logic [9:0] arm(input logic [9:0] t);
    return (t == 10'd0) ? 10'd1 : t;
  endfunction

  function automatic logic in_data_mv_lo(input logic [15:0] mv);
    return mv < blps_pkg::MV_MIN;
  endfunction

  assign steps = (fade_steps_r == 6'd0) ? 6'd1 : fade_steps_r;

  assign mv_clamped = (in_data_mv_lo(item_r.millivolts)) ? blps_pkg::MV_MIN :
                      (item_r.millivolts > blps_pkg::MV_MAX) ? blps_pkg::MV_MAX :
                      item_r.millivolts;
  assign mv_over = 11'(mv_clamped - blps_pkg::MV_MIN);

  // one plus the count of 150 mV thresholds cleared: independent compares
  always_comb begin
    goal_calc = 4'd1;
    for (int k = 1; k <= blps_pkg::GOAL_MAX; k++) begin
      if (mv_over >= 11'(k * blps_pkg::MV_PER_STEP)) begin
        goal_calc = goal_calc + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r   <= blps_pkg::RST_PWM_PERIOD;
      peak_percent_r <= blps_pkg::RST_PEAK_PERCENT;
      fade_steps_r   <= blps_pkg::RST_FADE_STEPS;
      step_ms_r      <= blps_pkg::RST_STEP_MS;
      hold_ms_r      <= blps_pkg::RST_HOLD_MS;
      gap_ms_r       <= blps_pkg::RST_GAP_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        blps_pkg::CFG_PWM_PERIOD:   pwm_period_r   <= cfg_wdata;
        blps_pkg::CFG_PEAK_PERCENT: peak_percent_r <= cfg_wdata[6:0];
        blps_pkg::CFG_FADE_STEPS:   fade_steps_r   <= cfg_wdata[5:0];
        blps_pkg::CFG_STEP_MS:      step_ms_r      <= cfg_wdata[7:0];
        blps_pkg::CFG_HOLD_MS:      hold_ms_r      <= cfg_wdata[9:0];
        blps_pkg::CFG_GAP_MS:       gap_ms_r       <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // one item's state update; width is filled in later by the scale chain
  always_comb begin
    logic [9:0] dl_dec;
    logic [5:0] ramp_inc;
    logic [5:0] ramp_dec;
    logic [3:0] done_inc;
    phase_nxt   = phase_r;
    ramp_nxt    = ramp_r;
    goal_nxt    = goal_r;
    done_nxt    = done_r;
    delay_nxt   = delay_r;
    running_nxt = running_r;
    width_nxt   = width_r;
    need_width  = 1'b0;
    dl_dec      = (delay_r != 10'd0) ? delay_r - 10'd1 : 10'd0;
    ramp_inc    = ramp_r + 6'd1;
    ramp_dec    = ramp_r - 6'd1;
    done_inc    = done_r + 4'd1;
    if (item_r.opcode == blps_pkg::OP_START) begin
      goal_nxt    = goal_calc;
      done_nxt    = 4'd0;
      phase_nxt   = PH_FADE_IN;
      ramp_nxt    = 6'd0;
      width_nxt   = 16'd0;
      running_nxt = 1'b1;
      delay_nxt   = arm({2'b00, step_ms_r});
    end else if (running_r) begin
      delay_nxt = dl_dec;
      if (dl_dec == 10'd0) begin
        case (phase_r)
          PH_FADE_IN: begin
            ramp_nxt   = ramp_inc;
            need_width = 1'b1;
            if (ramp_inc >= steps) begin
              phase_nxt = PH_HOLD;
              delay_nxt = arm(hold_ms_r);
            end else begin
              delay_nxt = arm({2'b00, step_ms_r});
            end
          end
          PH_HOLD: begin
            phase_nxt = PH_FADE_OUT;
            ramp_nxt  = steps;
            delay_nxt = arm({2'b00, step_ms_r});
          end
          PH_FADE_OUT: begin
            ramp_nxt   = ramp_dec;
            need_width = 1'b1;
            if (ramp_dec == 6'd0) begin
              done_nxt = done_inc;
              if (done_inc < goal_r) begin
                phase_nxt = PH_GAP;
                delay_nxt = arm(gap_ms_r);
              end else begin
                running_nxt = 1'b0;
                delay_nxt   = 10'd0;
              end
            end else begin
              delay_nxt = arm({2'b00, step_ms_r});
            end
          end
          default: begin
            phase_nxt = PH_FADE_IN;
            ramp_nxt  = 6'd0;
            delay_nxt = arm({2'b00, step_ms_r});
          end
        endcase
      end
    end
    if (cmd.width_load) begin
      width_nxt = (width_q[22:16] != '0) ? 16'hFFFF : width_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FADE_IN;
      ramp_r    <= '0;
      goal_r    <= '0;
      done_r    <= '0;
      delay_r   <= '0;
      running_r <= 1'b0;
      width_r   <= '0;
    end else if (cmd.exec) begin
      phase_r   <= phase_nxt;
      ramp_r    <= ramp_nxt;
      goal_r    <= goal_nxt;
      done_r    <= done_nxt;
      delay_r   <= delay_nxt;
      running_r <= running_nxt;
      width_r   <= width_nxt;
    end else if (cmd.width_load) begin
      width_r <= width_nxt;
    end
  end

  // width = period * (step * peak / steps) / 100
  assign pct_num   = {7'd0, ramp_r} * {6'd0, peak_percent_r};
  assign prod_calc = {13'd0, pwm_period_r} * {16'd0, div_q};

  // product / 100 = (product / 4) / 25 through the reciprocal, top 23 bits
  assign scale_mul = {28'd0, prod_r[blps_pkg::PROD_W-1:2]} * {27'd0, blps_pkg::DIV100_RECIP};
  assign width_q   = scale_mul[54:32];

  assign div_dividend = pct_num;
  assign div_divisor  = {1'b0, steps};

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_r <= prod_calc;
    end
  end

  blps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.pulse_width    <= width_r;
      out_r.active         <= running_r;
      out_r.pulses_planned <= goal_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign sts.need_width = need_width;
  assign sts.div_busy   = div_busy;
  assign sts.out_busy   = out_valid_r && out_stall;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (delay_r == 10'd0))
    else $error("delay armed while idle");

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

FILE: hw/rtl/blps_ctrl.sv
module blps_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  blps_pkg::sts_t  sts,
  output blps_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_D1GO,
    S_DIV1,
    S_MUL,
    S_SCALE,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = sts.need_width ? S_D1GO : S_OUT;
      S_D1GO:  state_nxt = S_DIV1;
      S_DIV1:  if (!sts.div_busy) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_OUT;
      S_OUT:   if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign cmd.capture    = (state_r == S_IDLE) && in_valid;
  assign cmd.exec       = (state_r == S_EXEC);
  assign cmd.div_start  = (state_r == S_D1GO);
  assign cmd.mul_load   = (state_r == S_MUL);
  assign cmd.width_load = (state_r == S_SCALE);
  assign cmd.out_load   = (state_r == S_OUT) && !sts.out_busy;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted beat not executed");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV1) && sts.div_busy) |=> (state_r == S_DIV1))
    else $error("left divide before quotient ready");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && sts.out_busy) |=> (state_r == S_OUT))
    else $error("left result stage while output full");

endmodule

FILE: hw/rtl/battery_level_led_pulse_sequencer_core.sv
// Battery level LED pulse sequencer.
// Input channel (in_valid / in_stall / in_data): each beat is either a 1 ms
// tick or a start command carrying the battery voltage in millivolts.
// Result channel (out_valid / out_stall / out_data): exactly one beat per
// input beat, showing the pulse width, the active flag and the planned pulse
// count after that input has been applied.
// Config port (cfg_we / cfg_index / cfg_wdata): write-only, one register per
// cycle; write only while no beat is in flight.
// A start, an idle tick or a tick that only counts down the delay passes
// from accept through the state update straight to the result register.
// A tick that moves a fade step recomputes the width: a 13-step radix-2
// divider forms step * percent / steps, one stage multiplies by the period
// and one divides by 100 through a reciprocal multiply.
// One beat is handled at a time; the next input is accepted while the
// previous result still sits in the output register.
// Reset (rst_n low, synchronous): config returns to its defaults, the
// sequence goes idle with width 0 and zero planned pulses, output empty.
// When out_stall is high the result holds; a finished beat waits in the
// controller and in_stall stays high until the output register frees.
module battery_level_led_pulse_sequencer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  blps_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output blps_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [blps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  blps_pkg::cmd_t cmd;
  blps_pkg::sts_t sts;

  // sequencing of capture, update, divide, scale and result load
  blps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // config, phase state, width arithmetic and output register
  blps_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
